### src/fpr_pkg.sv
package fpr_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic REG_PREAMBLE  = 1'b0;
  localparam logic REG_MAX_BYTES = 1'b1;

  localparam logic [7:0]  PREAMBLE_RESET  = 8'd126;
  localparam logic [16:0] MAX_BYTES_RESET = 17'd64;

  localparam logic [16:0] HDR_BYTES = 17'd6;
  localparam logic [16:0] HDR_LAST  = 17'd5;
  localparam logic [16:0] CHK_BYTES = 17'd2;
  localparam logic [8:0]  SUM_MOD   = 9'd255;
  localparam logic [7:0]  SUM_ZERO_CODE = 8'hFF;

  typedef enum logic [3:0] {
    ST_HUNT         = 4'd0,
    ST_PREAMBLE     = 4'd1,
    ST_HDR_BYTE     = 4'd2,
    ST_HDR_OK       = 4'd3,
    ST_LEN_MISMATCH = 4'd4,
    ST_TOO_LONG     = 4'd5,
    ST_PAYLOAD      = 4'd6,
    ST_CHK_BYTE     = 4'd7,
    ST_GOOD         = 4'd8,
    ST_BAD_CHK      = 4'd9
  } fpr_status_t;

  typedef enum logic {
    PH_HUNT  = 1'b0,
    PH_FRAME = 1'b1
  } fpr_phase_t;

  typedef struct packed {
    logic [7:0]  preamble_value;
    logic [16:0] max_packet_bytes;
  } fpr_cfg_t;

  typedef struct packed {
    logic clr;
    logic add;
  } fpr_sum_ctl_t;

  typedef struct packed {
    fpr_status_t status;
    logic [7:0]  data_byte;
    logic [15:0] frame_type;
    logic [15:0] payload_length;
    logic        packet_end;
  } fpr_result_t;

endpackage

### src/fpr_rx_if.sv
interface fpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### src/fpr_res_if.sv
interface fpr_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  data_byte;
  logic [15:0] frame_type;
  logic [15:0] payload_length;
  logic        packet_end;

  modport source (
    output valid, output status, output data_byte, output frame_type,
    output payload_length, output packet_end, input ready
  );
  modport sink (
    input valid, input status, input data_byte, input frame_type,
    input payload_length, input packet_end, output ready
  );
endinterface

### src/fpr_cfg_regs.sv
module fpr_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fpr_pkg::CFG_AW-1:0] paddr,
  input  logic [fpr_pkg::CFG_DW-1:0] pwdata,
  output logic [fpr_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output fpr_pkg::fpr_cfg_t          cfg
);
  import fpr_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_value   <= PREAMBLE_RESET;
      cfg.max_packet_bytes <= MAX_BYTES_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_PREAMBLE:  cfg.preamble_value   <= pwdata[7:0];
        REG_MAX_BYTES: cfg.max_packet_bytes <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PREAMBLE:  prdata = {24'd0, cfg.preamble_value};
      REG_MAX_BYTES: prdata = {15'd0, cfg.max_packet_bytes};
      default:       prdata = '0;
    endcase
  end

endmodule

### src/fpr_fletcher.sv
module fpr_fletcher (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  fpr_pkg::fpr_sum_ctl_t ctl,
  input  logic [7:0]            data,
  output logic [7:0]            sum_a,
  output logic [7:0]            sum_b
);
  import fpr_pkg::*;

  logic [8:0] a_raw;
  logic [7:0] sum_a_next;
  logic [8:0] b_raw;
  logic [7:0] sum_b_next;

  // mod-255 running sums, one conditional subtract each
  always_comb begin
    a_raw      = {1'b0, sum_a} + {1'b0, data};
    sum_a_next = (a_raw >= SUM_MOD) ? 8'(a_raw - SUM_MOD) : a_raw[7:0];
    b_raw      = {1'b0, sum_b} + {1'b0, sum_a_next};
    sum_b_next = (b_raw >= SUM_MOD) ? 8'(b_raw - SUM_MOD) : b_raw[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a <= '0;
      sum_b <= '0;
    end else if (step) begin
      if (ctl.clr) begin
        sum_a <= '0;
        sum_b <= '0;
      end else if (ctl.add) begin
        sum_a <= sum_a_next;
        sum_b <= sum_b_next;
      end
    end
  end

endmodule

### src/fpr_framer.sv
module fpr_framer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data,
  input  fpr_pkg::fpr_cfg_t    cfg,
  output fpr_pkg::fpr_result_t result
);
  import fpr_pkg::*;

  fpr_phase_t   phase;
  fpr_phase_t   phase_next;
  logic [16:0]  byte_count;
  logic [16:0]  expected_total;
  logic [7:0]   hdr [0:4];
  logic [15:0]  type_reg;
  logic [15:0]  length_reg;
  logic [7:0]   received_check_a;

  fpr_sum_ctl_t sum_ctl;
  logic [7:0]   sum_a;
  logic [7:0]   sum_b;

  logic         hdr_wr;
  logic         hdr_ok;
  logic         chk_a_wr;
  logic         go_hunt;
  logic [15:0]  hdr_type;
  logic [15:0]  hdr_len;
  logic [15:0]  hdr_cpl;
  logic [16:0]  hdr_total;
  logic [17:0]  pos_chk;
  logic [7:0]   chk_a;
  logic [7:0]   chk_b;

  fpr_fletcher u_fletcher (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .ctl   (sum_ctl),
    .data  (data),
    .sum_a (sum_a),
    .sum_b (sum_b)
  );

  assign hdr_type  = {hdr[0], hdr[1]};
  assign hdr_len   = {hdr[2], hdr[3]};
  assign hdr_cpl   = {hdr[4], data};
  assign hdr_total = {1'b0, hdr_len} + HDR_BYTES + CHK_BYTES;
  assign pos_chk   = {1'b0, byte_count} + {1'b0, CHK_BYTES};
  assign chk_a     = (sum_a == 8'd0) ? SUM_ZERO_CODE : sum_a;
  assign chk_b     = (sum_b == 8'd0) ? SUM_ZERO_CODE : sum_b;

  always_comb begin
    result                = '0;
    result.status         = ST_HUNT;
    result.data_byte      = data;
    sum_ctl               = '0;
    hdr_wr                = 1'b0;
    hdr_ok                = 1'b0;
    chk_a_wr              = 1'b0;
    go_hunt               = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (data == cfg.preamble_value) begin
          result.status = ST_PREAMBLE;
          sum_ctl.clr   = 1'b1;
        end
      end
      PH_FRAME: begin
        if (byte_count < HDR_BYTES) begin
          hdr_wr        = 1'b1;
          sum_ctl.add   = 1'b1;
          result.status = ST_HDR_BYTE;
          if (byte_count == HDR_LAST) begin
            if (hdr_len != ~hdr_cpl) begin
              result.status     = ST_LEN_MISMATCH;
              result.packet_end = 1'b1;
              go_hunt           = 1'b1;
            end else if (hdr_total > cfg.max_packet_bytes) begin
              result.status     = ST_TOO_LONG;
              result.packet_end = 1'b1;
              go_hunt           = 1'b1;
            end else begin
              hdr_ok                = 1'b1;
              result.status         = ST_HDR_OK;
              result.frame_type     = hdr_type;
              result.payload_length = hdr_len;
            end
          end
        end else if (pos_chk < {1'b0, expected_total}) begin
          sum_ctl.add           = 1'b1;
          result.status         = ST_PAYLOAD;
          result.frame_type     = type_reg;
          result.payload_length = length_reg;
        end else if (pos_chk == {1'b0, expected_total}) begin
          chk_a_wr              = 1'b1;
          result.status         = ST_CHK_BYTE;
          result.frame_type     = type_reg;
          result.payload_length = length_reg;
        end else begin
          result.status = (chk_a == received_check_a && chk_b == data) ? ST_GOOD
                                                                        : ST_BAD_CHK;
          result.frame_type     = type_reg;
          result.payload_length = length_reg;
          result.packet_end     = 1'b1;
          go_hunt               = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HUNT:  if (data == cfg.preamble_value) phase_next = PH_FRAME;
      PH_FRAME: if (go_hunt) phase_next = PH_HUNT;
      default:  phase_next = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      byte_count     <= '0;
      expected_total <= '0;
      type_reg       <= '0;
      length_reg     <= '0;
    end else if (step) begin
      phase <= phase_next;
      if (phase == PH_HUNT || go_hunt) begin
        byte_count <= '0;
      end else begin
        byte_count <= byte_count + 17'd1;
      end
      if (hdr_ok) begin
        expected_total <= hdr_total;
        type_reg       <= hdr_type;
        length_reg     <= hdr_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && hdr_wr && byte_count < HDR_LAST) begin
      hdr[byte_count[2:0]] <= data;
    end
    if (step && chk_a_wr) begin
      received_check_a <= data;
    end
  end

endmodule

### src/framed_packet_receiver_fletcher16.sv
// Channel  Dir  Payload                                                   Handshake
// rx       in   rx_byte[7:0]                                              valid/ready
// res      out  status[3:0] data_byte[7:0] frame_type[15:0]
//               payload_length[15:0] packet_end                           valid/ready
// cfg      in   APB: paddr[2:0], 0x0 preamble_value, 0x4 max_packet_bytes  pready=1
//
// One byte per cycle while res.ready is high; each byte passes input then result register.
// Input register feeds the framer and Fletcher sums; the result register holds the status.
// rst is synchronous, active high; it restores register defaults and hunting state.
// A stalled result stalls the input register; rx.ready falls only when both are full
// and res.ready is low.
module framed_packet_receiver_fletcher16 (
  input  logic                       clk,
  input  logic                       rst,
  fpr_rx_if.sink                     rx,
  fpr_res_if.source                  res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fpr_pkg::CFG_AW-1:0] paddr,
  input  logic [fpr_pkg::CFG_DW-1:0] pwdata,
  output logic [fpr_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import fpr_pkg::*;

  fpr_cfg_t    cfg;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_adv;
  logic        out_free;
  fpr_result_t res_comb;
  fpr_result_t res_q;
  logic        res_valid;

  fpr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpr_framer u_framer (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_adv),
    .data   (s1_byte),
    .cfg    (cfg),
    .result (res_comb)
  );

  assign out_free = !res_valid || res.ready;
  assign s1_adv   = s1_valid && out_free;
  assign rx.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_q <= res_comb;
    end
  end

  assign res.valid          = res_valid;
  assign res.status         = res_q.status;
  assign res.data_byte      = res_q.data_byte;
  assign res.frame_type     = res_q.frame_type;
  assign res.payload_length = res_q.payload_length;
  assign res.packet_end     = res_q.packet_end;

`ifndef SYNTH
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_byte)))
    else $error("input register lost a held transaction");

  a_s1_to_res: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (res_valid && res_q.data_byte == $past(s1_byte)))
    else $error("result register did not take the advancing transaction");

  a_end_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.packet_end) |->
      (res_q.status == ST_LEN_MISMATCH || res_q.status == ST_TOO_LONG ||
       res_q.status == ST_GOOD || res_q.status == ST_BAD_CHK))
    else $error("packet_end with a non-terminal status");
`endif

endmodule
